/* rtl/ccd_pkg.sv */
// Package: shared types, constants and helpers for the ChaCha20 generator.
`timescale 1ns / 1ps
package ccd_pkg;

  localparam int unsigned MaxRequestBytes = 256;

  localparam logic [1:0] KIND_SEED  = 2'd0;
  localparam logic [1:0] KIND_GEN   = 2'd1;
  localparam logic [1:0] KIND_MIX   = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef logic [15:0][31:0] blk_t;

  // Control between sequencer and block core.
  typedef struct packed {
    logic start;
  } core_req_t;

  typedef struct packed {
    logic done;
  } core_sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage

/* rtl/ccd_core.sv */
// Block core: ChaCha20 block function, one quarter round per cycle.
`timescale 1ns / 1ps
module ccd_core (
  input  logic             clk,
  input  logic             rst_n,
  input  ccd_pkg::core_req_t req,
  input  ccd_pkg::blk_t    init,
  output ccd_pkg::core_sts_t sts,
  output ccd_pkg::blk_t    blk
);

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_RUN  = 3'b010,
    C_FIN  = 3'b100
  } cstate_t;

  cstate_t state_r, state_nxt;
  ccd_pkg::blk_t w_r, w_nxt;
  logic [6:0] qr_r, qr_nxt;

  logic [3:0] ia, ib, ic, id;
  logic [31:0] a0, b0, c0, d0, a1, b1, c1, d1, a2, b2, c2, d2;

  // Pick the quarter-round lanes: column rounds then diagonal rounds.
  always_comb begin
    logic [1:0] k;
    k = qr_r[1:0];
    ia = {2'b00, k};
    if (!qr_r[2]) begin
      ib = {2'b01, k};
      ic = {2'b10, k};
      id = {2'b11, k};
    end else begin
      ib = {2'b01, k + 2'd1};
      ic = {2'b10, k + 2'd2};
      id = {2'b11, k + 2'd3};
    end
  end

  // Shared quarter-round unit.
  always_comb begin
    a0 = w_r[ia] + w_r[ib];
    d0 = ccd_pkg::rotl(w_r[id] ^ a0, 16);
    c0 = w_r[ic] + d0;
    b0 = ccd_pkg::rotl(w_r[ib] ^ c0, 12);
    a1 = a0 + b0;
    d1 = ccd_pkg::rotl(d0 ^ a1, 8);
    c1 = c0 + d1;
    b1 = ccd_pkg::rotl(b0 ^ c1, 7);
    a2 = a1; b2 = b1; c2 = c1; d2 = d1;
  end

  always_comb begin
    state_nxt = state_r;
    w_nxt = w_r;
    qr_nxt = qr_r;
    case (state_r)
      C_IDLE: begin
        if (req.start) begin
          w_nxt = init;
          qr_nxt = '0;
          state_nxt = C_RUN;
        end
      end
      C_RUN: begin
        w_nxt[ia] = a2;
        w_nxt[ib] = b2;
        w_nxt[ic] = c2;
        w_nxt[id] = d2;
        qr_nxt = qr_r + 7'd1;
        if (qr_r == 7'd79) state_nxt = C_FIN;
      end
      C_FIN: begin
        for (int i = 0; i < 16; i++) w_nxt[i] = w_r[i] + init[i];
        state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      qr_r <= '0;
    end else begin
      state_r <= state_nxt;
      qr_r <= qr_nxt;
    end
    w_r <= w_nxt;
  end

  logic fin_r;
  always_ff @(posedge clk) begin
    if (!rst_n) fin_r <= 1'b0;
    else fin_r <= (state_r == C_FIN);
  end

  assign sts.done = fin_r;
  assign blk = w_r;

endmodule

/* rtl/chacha20_drng_engine.sv */
// Top level: ChaCha20 deterministic generator with seed, generate, mix and clear.
// A block runs as launch, 80 quarter rounds, feed-forward add, then the done flag.
// Seed word: its bytes are absorbed in turn, plus a block per key update. Mix and clear:
// handled in idle. Generate: a block per 64 bytes, its words streamed as the sink takes
// them, a rekey step, plus a block when fewer than eight words of the last block remain.
// Not ready while an item runs. Sync active-low reset zeroes key, counter, nonce, offset.
`timescale 1ns / 1ps
module chacha20_drng_engine #(
  parameter int unsigned MAX_REQUEST_BYTES = ccd_pkg::MaxRequestBytes
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_payload,
  input  logic [8:0]  in_byte_count,
  input  logic        in_end_of_seed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_random_word,
  output logic [2:0]  out_valid_bytes,
  output logic        out_last
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEED   = 7'b0000010,
    S_UPD    = 7'b0000100,
    S_GBLK   = 7'b0001000,
    S_GOUT   = 7'b0010000,
    S_GUPD   = 7'b0100000,
    S_WAIT   = 7'b1000000
  } state_t;

  // Return point after a block computation.
  typedef enum logic [1:0] {
    R_SEED = 2'd0,
    R_EOS  = 2'd1,
    R_GEN  = 2'd2,
    R_FIN  = 2'd3
  } ret_t;

  state_t state_r, state_nxt;
  ret_t ret_r, ret_nxt;
  logic [7:0][31:0] key_r, key_nxt;
  logic [31:0] ctr_r, ctr_nxt;
  logic [2:0][31:0] nonce_r, nonce_nxt;
  logic [4:0] off_r, off_nxt;
  logic [63:0] pay_r, pay_nxt;
  logic [2:0] sn_r, sn_nxt;
  logic eos_r, eos_nxt;
  logic [8:0] rem_r, rem_nxt;
  logic [3:0] wi_r, wi_nxt;
  logic [4:0] used_r, used_nxt;
  logic ov_r, ov_nxt;
  logic [31:0] ow_r, ow_nxt;
  logic [2:0] ob_r, ob_nxt;
  logic ol_r, ol_nxt;

  ccd_pkg::core_req_t creq;
  ccd_pkg::core_sts_t csts;
  ccd_pkg::blk_t cinit, cblk;

  always_comb begin
    cinit[0] = ccd_pkg::SIGMA0;
    cinit[1] = ccd_pkg::SIGMA1;
    cinit[2] = ccd_pkg::SIGMA2;
    cinit[3] = ccd_pkg::SIGMA3;
    for (int i = 0; i < 8; i++) cinit[4 + i] = key_r[i];
    cinit[12] = ctr_r;
    for (int i = 0; i < 3; i++) cinit[13 + i] = nonce_r[i];
  end

  ccd_core u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (creq),
    .init (cinit),
    .sts  (csts),
    .blk  (cblk)
  );

  localparam logic [8:0] MaxReq = 9'(MAX_REQUEST_BYTES);

  logic [8:0] take;
  logic [6:0] take_m;
  logic [4:0] words;
  logic [8:0] vb_full;
  logic [2:0] vb;
  logic [31:0] wsel;
  logic [95:0] nonce_inc;

  assign take = (rem_r >= 9'd64) ? 9'd64 : rem_r;
  assign take_m = take[6:0];
  assign words = 5'((take_m + 7'd3) >> 2);
  assign vb_full = take - {3'b000, wi_r, 2'b00};
  assign vb = (vb_full > 9'd4) ? 3'd4 : vb_full[2:0];
  assign wsel = cblk[wi_r];
  assign nonce_inc = {nonce_r[2], nonce_r[1], nonce_r[0]} + 96'd1;

  always_comb begin
    logic [8:0] cnt;
    logic [31:0] mask;
    state_nxt = state_r;
    ret_nxt = ret_r;
    key_nxt = key_r;
    ctr_nxt = ctr_r;
    nonce_nxt = nonce_r;
    off_nxt = off_r;
    pay_nxt = pay_r;
    sn_nxt = sn_r;
    eos_nxt = eos_r;
    rem_nxt = rem_r;
    wi_nxt = wi_r;
    used_nxt = used_r;
    ov_nxt = ov_r;
    ow_nxt = ow_r;
    ob_nxt = ob_r;
    ol_nxt = ol_r;
    creq.start = 1'b0;
    in_ready = (state_r == S_IDLE);
    cnt = in_byte_count;
    mask = '1;

    if (ov_r && out_ready) ov_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            ccd_pkg::KIND_SEED: begin
              pay_nxt = in_payload;
              sn_nxt = (cnt > 9'd4) ? 3'd4 : cnt[2:0];
              eos_nxt = in_end_of_seed;
              state_nxt = S_SEED;
            end
            ccd_pkg::KIND_GEN: begin
              rem_nxt = (cnt > MaxReq) ? MaxReq : cnt;
              used_nxt = 5'd16;
              if (cnt == 9'd0) begin
                state_nxt = S_UPD;
                ret_nxt = R_FIN;
              end else begin
                state_nxt = S_UPD;
                ret_nxt = R_GEN;
              end
            end
            ccd_pkg::KIND_MIX: begin
              key_nxt[0] = key_r[0] ^ in_payload[31:0];
              key_nxt[1] = key_r[1] ^ in_payload[63:32];
            end
            default: begin
              key_nxt = '0;
              ctr_nxt = '0;
              nonce_nxt = '0;
              off_nxt = '0;
            end
          endcase
        end
      end
      // Absorb one seed byte per cycle, pausing for a block at each key update.
      S_SEED: begin
        if (sn_r != 3'd0) begin
          key_nxt[off_r[4:2]] = key_r[off_r[4:2]] ^
                                ({24'd0, pay_r[7:0]} << {off_r[1:0], 3'b000});
          pay_nxt = pay_r >> 8;
          sn_nxt = sn_r - 3'd1;
          off_nxt = off_r + 5'd1;
          if (off_r == 5'd31) begin
            state_nxt = S_UPD;
            ret_nxt = R_SEED;
          end
        end else if (eos_r && off_r != 5'd0) begin
          off_nxt = '0;
          state_nxt = S_UPD;
          ret_nxt = R_EOS;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      // Launch a block.
      S_UPD: begin
        creq.start = 1'b1;
        state_nxt = S_WAIT;
      end
      // Advance the counter once the block is finished, then stream it or fold it into the key.
      S_WAIT: begin
        if (csts.done) begin
          ctr_nxt = ctr_r + 32'd1;
          case (ret_r)
            R_GEN: begin
              wi_nxt = '0;
              state_nxt = S_GOUT;
            end
            default: begin
              for (int i = 0; i < 8; i++) key_nxt[i] = key_r[i] ^ cblk[i];
              nonce_nxt = nonce_inc;
              state_nxt = (ret_r == R_SEED) ? S_SEED : S_IDLE;
            end
          endcase
        end
      end
      // Stream the block's words.
      S_GOUT: begin
        if (!ov_r || out_ready) begin
          mask = (vb == 3'd4) ? 32'hFFFF_FFFF : ((32'd1 << {vb, 3'b000}) - 32'd1);
          ov_nxt = 1'b1;
          ow_nxt = wsel & mask;
          ob_nxt = vb;
          ol_nxt = (rem_r == take) && (5'(wi_r) + 5'd1 == words);
          wi_nxt = wi_r + 4'd1;
          if (5'(wi_r) + 5'd1 == words) begin
            used_nxt = (take == 9'd64) ? 5'd16 : words;
            rem_nxt = rem_r - take;
            if (rem_r == take) state_nxt = S_GUPD;
            else state_nxt = S_UPD;
          end
        end
      end
      // Final key update from leftover words or a fresh block.
      S_GUPD: begin
        if (used_r > 5'd8) begin
          state_nxt = S_UPD;
          ret_nxt = R_FIN;
        end else begin
          for (int i = 0; i < 8; i++) key_nxt[i] = key_r[i] ^ cblk[4'(i) + used_r[3:0]];
          nonce_nxt = nonce_inc;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= R_FIN;
      key_r <= '0;
      ctr_r <= '0;
      nonce_r <= '0;
      off_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      key_r <= key_nxt;
      ctr_r <= ctr_nxt;
      nonce_r <= nonce_nxt;
      off_r <= off_nxt;
      ov_r <= ov_nxt;
    end
    pay_r <= pay_nxt;
    sn_r <= sn_nxt;
    eos_r <= eos_nxt;
    rem_r <= rem_nxt;
    wi_r <= wi_nxt;
    used_r <= used_nxt;
    ow_r <= ow_nxt;
    ob_r <= ob_nxt;
    ol_r <= ol_nxt;
  end

  assign out_valid = ov_r;
  assign out_random_word = ow_r;
  assign out_valid_bytes = ob_r;
  assign out_last = ol_r;

endmodule

/* rtl/ccd_checker.sv */
// Checker: port-level properties of the generator, bound to the top level.
`timescale 1ns / 1ps
module ccd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_random_word,
  input logic [2:0]  out_valid_bytes,
  input logic        out_last
);

  // Hold a stalled result beat.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_random_word))
    else $error("stalled beat changed");

  // Byte count is always 1..4.
  a_vb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_valid_bytes != 3'd0 && out_valid_bytes <= 3'd4))
    else $error("bad valid_bytes");

  // Short word is only the last word.
  a_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_bytes != 3'd4 |-> out_last)
    else $error("short word not last");

  // With one valid byte, the bytes above it read as zero.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_bytes == 3'd1 |-> out_random_word[31:8] == 24'd0)
    else $error("invalid bytes not zero");

  // Keep a stalled result beat while a new input beat is taken.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_valid && !out_ready |=> out_valid)
    else $error("beat dropped");

endmodule

bind chacha20_drng_engine ccd_checker u_ccd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_random_word(out_random_word),
  .out_valid_bytes(out_valid_bytes),
  .out_last       (out_last)
);

/* verif/chacha20_drng_engine_tb.sv */
// Testbench for the ChaCha20 generator: queue-fed driver, clocked monitor, scoreboard.
`timescale 1ns / 1ps
module chacha20_drng_engine_tb;

  localparam int unsigned WatchdogLimit = 40000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] payload;
    logic [8:0]  byte_count;
    logic        end_of_seed;
  } drng_req_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
  } drng_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [63:0] in_payload;
  logic [8:0]  in_byte_count;
  logic        in_end_of_seed;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_random_word;
  logic [2:0]  out_valid_bytes;
  logic        out_last;

  chacha20_drng_engine uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_payload(in_payload), .in_byte_count(in_byte_count),
    .in_end_of_seed(in_end_of_seed),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_random_word(out_random_word), .out_valid_bytes(out_valid_bytes),
    .out_last(out_last)
  );

  // Shadow generator state
  logic [31:0] key_sh [8];
  logic [31:0] ctr_sh;
  logic [31:0] nonce_sh [3];
  logic [5:0]  seed_off_sh;

  drng_req_t  pending_reqs [$];
  drng_word_t expected_words [$];
  int         errors;
  int         idle_cycles;
  bit         calm;
  bit         hold_off;
  bit         stim_done;

  function automatic logic [31:0] rol32(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Compute one ChaCha20 block from the shadow state and bump the counter
  task automatic chacha_block(output logic [31:0] blk [16]);
    logic [31:0] init [16];
    logic [31:0] w [16];
    int qr [8][4];
    qr = '{'{0,4,8,12}, '{1,5,9,13}, '{2,6,10,14}, '{3,7,11,15},
           '{0,5,10,15}, '{1,6,11,12}, '{2,7,8,13}, '{3,4,9,14}};
    init[0] = ccd_pkg::SIGMA0; init[1] = ccd_pkg::SIGMA1;
    init[2] = ccd_pkg::SIGMA2; init[3] = ccd_pkg::SIGMA3;
    for (int i = 0; i < 8; i++) init[4 + i] = key_sh[i];
    init[12] = ctr_sh;
    for (int i = 0; i < 3; i++) init[13 + i] = nonce_sh[i];
    w = init;
    for (int r = 0; r < 10; r++) begin
      for (int q = 0; q < 8; q++) begin
        int a, b, c, d;
        a = qr[q][0]; b = qr[q][1]; c = qr[q][2]; d = qr[q][3];
        w[a] += w[b]; w[d] = rol32(w[d] ^ w[a], 16);
        w[c] += w[d]; w[b] = rol32(w[b] ^ w[c], 12);
        w[a] += w[b]; w[d] = rol32(w[d] ^ w[a], 8);
        w[c] += w[d]; w[b] = rol32(w[b] ^ w[c], 7);
      end
    end
    for (int i = 0; i < 16; i++) blk[i] = w[i] + init[i];
    ctr_sh += 1;
  endtask

  // Rekey from leftover block words or a fresh block, then bump the nonce
  task automatic rekey(input logic [31:0] blk [16], input int used);
    logic [31:0] fresh [16];
    if (used > 8) begin
      chacha_block(fresh);
      for (int i = 0; i < 8; i++) key_sh[i] ^= fresh[i];
    end else begin
      for (int i = 0; i < 8; i++) key_sh[i] ^= blk[i + used];
    end
    nonce_sh[0] += 1;
    if (nonce_sh[0] == 0) begin
      nonce_sh[1] += 1;
      if (nonce_sh[1] == 0) nonce_sh[2] += 1;
    end
  endtask

  task automatic clear_shadow();
    for (int i = 0; i < 8; i++) key_sh[i] = '0;
    for (int i = 0; i < 3; i++) nonce_sh[i] = '0;
    ctr_sh = '0;
    seed_off_sh = '0;
  endtask

  // Advance the shadow state by one accepted beat and queue its words
  task automatic predict_words(input drng_req_t r);
    logic [31:0] blk [16];
    int n, rem, take, nw, used, vb;
    logic [31:0] v;
    drng_word_t ew;
    for (int i = 0; i < 16; i++) blk[i] = '0;
    case (r.kind)
      ccd_pkg::KIND_SEED: begin
        n = (r.byte_count > 4) ? 4 : r.byte_count;
        for (int i = 0; i < n; i++) begin
          int off;
          off = seed_off_sh & 31;
          key_sh[off >> 2] ^= {24'd0, r.payload[8*i +: 8]} << (8 * (off & 3));
          off++;
          if (off == 32) begin
            rekey(blk, 16);
            off = 0;
          end
          seed_off_sh = 6'(off);
        end
        if (r.end_of_seed && seed_off_sh != 0) begin
          rekey(blk, 16);
          seed_off_sh = '0;
        end
      end
      ccd_pkg::KIND_GEN: begin
        rem = (r.byte_count > ccd_pkg::MaxRequestBytes) ? ccd_pkg::MaxRequestBytes
                                                        : r.byte_count;
        used = 16;
        while (rem > 0) begin
          take = (rem >= 64) ? 64 : rem;
          nw = (take + 3) / 4;
          chacha_block(blk);
          for (int i = 0; i < nw; i++) begin
            vb = take - 4 * i;
            if (vb > 4) vb = 4;
            v = blk[i];
            if (vb < 4) v &= (32'd1 << (8 * vb)) - 1;
            ew.word = v;
            ew.nbytes = vb[2:0];
            ew.last = (rem == take) && (i + 1 == nw);
            expected_words.push_back(ew);
          end
          used = (take == 64) ? 16 : nw;
          rem -= take;
        end
        rekey(blk, used);
      end
      ccd_pkg::KIND_MIX: begin
        key_sh[0] ^= r.payload[31:0];
        key_sh[1] ^= r.payload[63:32];
      end
      default: clear_shadow();
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  function automatic drng_req_t mk(logic [1:0] k, logic [63:0] p, logic [8:0] c, logic e);
    drng_req_t r;
    r.kind = k; r.payload = p; r.byte_count = c; r.end_of_seed = e;
    return r;
  endfunction

  // Mostly small generate sizes, occasionally the largest
  function automatic logic [8:0] gen_size();
    int s;
    s = $urandom_range(0, 99);
    if (s < 5) return 9'($urandom_range(257, 511));
    if (s < 15) return 9'($urandom_range(129, 256));
    return 9'($urandom_range(0, 72));
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stimulus
  initial begin
    logic [1:0] k;
    int msg_len;
    errors = 0;
    stim_done = 1'b0;
    clear_shadow();
    // Directed beats
    pending_reqs.push_back(mk(ccd_pkg::KIND_GEN, '0, 9'd0, 1'b0));
    pending_reqs.push_back(mk(ccd_pkg::KIND_GEN, '0, 9'd1, 1'b0));
    pending_reqs.push_back(mk(ccd_pkg::KIND_GEN, '0, 9'd64, 1'b0));
    pending_reqs.push_back(mk(ccd_pkg::KIND_GEN, '0, 9'd33, 1'b0));
    pending_reqs.push_back(mk(ccd_pkg::KIND_GEN, '0, 9'd256, 1'b0));
    pending_reqs.push_back(mk(ccd_pkg::KIND_GEN, '0, 9'h1ff, 1'b0));
    pending_reqs.push_back(mk(ccd_pkg::KIND_SEED, '1, 9'd0, 1'b1));
    pending_reqs.push_back(mk(ccd_pkg::KIND_SEED, 64'h0123456789abcdef, 9'd3, 1'b0));
    pending_reqs.push_back(mk(ccd_pkg::KIND_GEN, '0, 9'd7, 1'b0));
    pending_reqs.push_back(mk(ccd_pkg::KIND_SEED, '1, 9'h1ff, 1'b1));
    for (int i = 0; i < 8; i++)
      pending_reqs.push_back(mk(ccd_pkg::KIND_SEED, 64'hdeadbeef00000000 | i, 9'd4, i == 7));
    pending_reqs.push_back(mk(ccd_pkg::KIND_SEED, 64'h55aa33cc, 9'd3, 1'b0));
    for (int i = 0; i < 8; i++)
      pending_reqs.push_back(mk(ccd_pkg::KIND_SEED, 64'hfedcba98, 9'd4, 1'b0));
    pending_reqs.push_back(mk(ccd_pkg::KIND_SEED, 64'h1, 9'd0, 1'b1));
    pending_reqs.push_back(mk(ccd_pkg::KIND_MIX, '1, 9'd0, 1'b0));
    pending_reqs.push_back(mk(ccd_pkg::KIND_GEN, '0, 9'd60, 1'b0));
    pending_reqs.push_back(mk(ccd_pkg::KIND_CLEAR, '1, '1, 1'b1));
    pending_reqs.push_back(mk(ccd_pkg::KIND_GEN, '0, 9'd4, 1'b0));
    // Random part: seed messages, requests, mixes and the odd clear
    while (pending_reqs.size() < 470) begin
      k = 2'($urandom_range(0, 3));
      if (k == ccd_pkg::KIND_SEED) begin
        msg_len = $urandom_range(1, 12);
        for (int i = 0; i < msg_len; i++)
          pending_reqs.push_back(mk(ccd_pkg::KIND_SEED, {$urandom, $urandom},
            ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(1, 4)),
            (i == msg_len - 1) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 20) == 0)));
      end else if (k == ccd_pkg::KIND_GEN || $urandom_range(0, 1) == 0) begin
        pending_reqs.push_back(mk(ccd_pkg::KIND_GEN, {$urandom, $urandom}, gen_size(),
                                  1'($urandom)));
      end else if (k == ccd_pkg::KIND_MIX) begin
        pending_reqs.push_back(mk(ccd_pkg::KIND_MIX, {$urandom, $urandom}, 9'($urandom),
                                  1'($urandom)));
      end else if ($urandom_range(0, 5) == 0) begin
        pending_reqs.push_back(mk(ccd_pkg::KIND_CLEAR, {$urandom, $urandom}, 9'($urandom),
                                  1'($urandom)));
      end
    end
    stim_done = 1'b1;
  end

  // Reset
  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: offer the head of the queue, idle at random outside the calm stretch
  initial begin
    in_valid = 1'b0; in_kind = '0; in_payload = '0; in_byte_count = '0;
    in_end_of_seed = 1'b0;
  end

  always @(posedge clk) begin
    drng_req_t r;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_words(pending_reqs.pop_front());
      end
      if ((!in_valid || in_ready) ) begin
        if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 21)) begin
          r = pending_reqs[0];
          in_valid <= 1'b1;
          in_kind <= r.kind;
          in_payload <= r.payload;
          in_byte_count <= r.byte_count;
          in_end_of_seed <= r.end_of_seed;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Calm stretch and receiver hold-off, both counted in cycles
  initial begin
    calm = 1'b0;
    hold_off = 1'b0;
    wait (rst_n);
    repeat (3000) @(posedge clk);
    calm = 1'b1;
    repeat (4000) @(posedge clk);
    calm = 1'b0;
    hold_off = 1'b1;
    repeat (2000) @(posedge clk);
    hold_off = 1'b0;
  end

  initial out_ready = 1'b0;

  // Monitor: check each accepted word against the oldest expected word
  always @(posedge clk) begin
    drng_word_t ew;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", out_random_word, '0);
        end else begin
          ew = expected_words.pop_front();
          if (out_random_word !== ew.word)
            report_mismatch("random_word", out_random_word, ew.word);
          if (out_valid_bytes !== ew.nbytes)
            report_mismatch("valid_bytes", 32'(out_valid_bytes), 32'(ew.nbytes));
          if (out_last !== ew.last)
            report_mismatch("last", 32'(out_last), 32'(ew.last));
        end
      end
      out_ready <= !hold_off && (calm || $urandom_range(0, 99) >= 21);
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // End of run
  initial begin
    @(posedge clk);
    while (!(stim_done && rst_n)) @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* chacha20_drng_engine.f */
rtl/ccd_pkg.sv
rtl/ccd_core.sv
rtl/chacha20_drng_engine.sv
rtl/ccd_checker.sv
verif/chacha20_drng_engine_tb.sv
